// ----- rtl/tfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfsc_pkg
// Shared types, register codes, constants and a root function for the transfer function
// segment classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsc_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int SIZE_W          = 9;
	localparam int CH_W            = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE  = 1'd1;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd256;
	localparam logic [CH_W-1:0]   STEP_BASE_RST  = 16'd2560;

	// request modes
	localparam logic MODE_WRITE    = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [7:0]      entry_index;
		logic [CH_W-1:0] entry_red;
		logic [CH_W-1:0] entry_green;
		logic [CH_W-1:0] entry_blue;
		logic [CH_W-1:0] entry_alpha;
		logic [CH_W-1:0] value_begin;
		logic [CH_W-1:0] value_end;
		logic [CH_W-1:0] segment_length;
	} in_req_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} out_res_t;

	// 2^(-2^-k) in Q1.30, each the floor square root of the one before,
	// starting from one half
	function automatic logic [30:0] root_at(input int k);
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bt;
		int          i;
		int          j;
		r = 64'd1 << 29;
		for (i = 1; i <= k; i++) begin
			n   = r << 30;
			res = '0;
			bt  = 64'd1 << 62;
			for (j = 0; j < 32; j++) begin
				if (n >= res + bt) begin
					n   = n - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			r = res;
		end
		return r[30:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/transfer_function_segment_classify.sv -----
// ----------------------------------------------------------------------------
// transfer_function_segment_classify
// RGBA transfer function lookup with linear interpolation, two-sample
// averaging, step-length opacity correction and RGB premultiply.
// ----------------------------------------------------------------------------
// Path: a classify request passes through stages s1..s60 and then the output register
//   before its result shows at out_valid; a table write request takes effect at its accept edge.
// Throughput: one request per cycle while in_stall is low; the 60-stage pipeline advances as a whole.
// in_stall rises only while both the output register and the skid register hold.
// Reset: clears all valid bits and the skid, loads table_size 256 and step_base
//   2560; table contents stay undefined until written.
`default_nettype none

module transfer_function_segment_classify #(
	parameter int TABLE_DEPTH = tfsc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tfsc_pkg::in_req_t                in_req,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tfsc_pkg::out_res_t               out_req
);

	import tfsc_pkg::*;

	localparam int HW     = $clog2(TABLE_DEPTH);
	localparam int BANK_D = (TABLE_DEPTH + 1) / 2;
	localparam int BW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
	localparam int PW     = CH_W + SIZE_W;
	localparam int LOG_N  = 16;
	localparam int DIV_N  = 21;
	localparam int EXP_N  = 16;
	localparam int NUM_W  = 37;

	typedef struct packed {
		logic [HW-1:0]   hd;
		logic [CH_W-1:0] f;
	} loc_t;

	typedef struct packed {
		logic [47:0] rgb;
		logic [4:0]  m;
		logic [30:0] mant;
		logic [15:0] frac;
		logic [15:0] len;
	} log_t;

	typedef struct packed {
		logic [47:0]      rgb;
		logic [NUM_W-1:0] rem;
		logic [DIV_N-1:0] quo;
		logic             ovf;
	} quo_t;

	typedef struct packed {
		logic [47:0]      rgb;
		logic [30:0]      prod;
		logic [DIV_N-1:0] quo;
		logic             ovf;
	} exp_t;

	// Find the head entry and the blend fraction; clamp to the edge entries.
	function automatic loc_t locate(input logic [PW-1:0] p, input logic [SIZE_W-1:0] sz);
		logic [PW-1:0] x;
		logic [PW-1:0] lim;
		loc_t          l;
		x   = p - PW'(32768);
		lim = (PW'(sz) - PW'(1)) << 16;
		if (p < PW'(32768)) begin
			l.hd = '0;
			l.f  = '0;
		end else if (x >= lim) begin
			l.hd = HW'(sz - SIZE_W'(1));
			l.f  = '0;
		end else begin
			l.hd = HW'(x >> 16);
			l.f  = x[15:0];
		end
		return l;
	endfunction

	// h + (t-h)*f, rounded; the tail is ignored at a zero fraction
	function automatic logic [15:0] interp(input logic [15:0] h, input logic [15:0] t,
			input logic [15:0] f);
		logic signed [16:0] d;
		logic signed [34:0] sum;
		if (f == '0) begin
			d = '0;
		end else begin
			d = $signed({1'b0, t}) - $signed({1'b0, h});
		end
		sum = $signed({3'b000, h, 16'h0000}) + 35'(d) * 35'($signed({1'b0, f}))
			+ 35'sd32768;
		return sum[31:16];
	endfunction

	// ---------------- configuration ----------------
	logic [SIZE_W-1:0] tsize_q;
	logic [CH_W-1:0]   base_q;
	logic [SIZE_W-1:0] size_eff;
	logic [CH_W-1:0]   base_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= TABLE_SIZE_RST;
			base_q  <= STEP_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TABLE_SIZE: tsize_q <= cfg_data[SIZE_W-1:0];
				REG_STEP_BASE:  base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp size to 2..TABLE_DEPTH, step base to at least 1
	always_comb begin
		if (tsize_q < SIZE_W'(2)) begin
			size_eff = SIZE_W'(2);
		end else if (int'(tsize_q) > TABLE_DEPTH) begin
			size_eff = SIZE_W'(TABLE_DEPTH);
		end else begin
			size_eff = tsize_q;
		end
	end
	assign base_eff = (base_q == '0) ? CH_W'(1) : base_q;

	// ---------------- handshake ----------------
	// The pipeline advances as a whole whenever the skid register is free.
	logic     adv;
	logic     in_take;
	logic     skid_v_q;
	out_res_t skid_q;

	assign adv      = ~skid_v_q;
	assign in_stall = skid_v_q;
	assign in_take  = in_valid & ~skid_v_q;

	// ---------------- table write ----------------
	// Split even and odd entries so head and head+1 come from different banks.
	logic [63:0]   even_mem [BANK_D];
	logic [63:0]   odd_mem  [BANK_D];
	logic          wr_en;
	logic          wr_odd;
	logic [BW-1:0] wr_addr;
	logic [63:0]   wr_data;

	assign wr_en   = in_take && (in_req.mode == MODE_WRITE)
		&& (int'(in_req.entry_index) < TABLE_DEPTH);
	assign wr_odd  = in_req.entry_index[0];
	assign wr_addr = BW'(in_req.entry_index >> 1);
	assign wr_data = {in_req.entry_alpha, in_req.entry_blue, in_req.entry_green,
		in_req.entry_red};

	// ---------------- s1: scale values to table positions ----------------
	logic          v_s1;
	logic [PW-1:0] p_b_s1;
	logic [PW-1:0] p_e_s1;
	logic [15:0]   len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_take & (in_req.mode == MODE_CLASSIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_b_s1 <= PW'(in_req.value_begin) * PW'(size_eff);
			p_e_s1 <= PW'(in_req.value_end) * PW'(size_eff);
			len_s1 <= in_req.segment_length;
		end
	end

	// ---------------- s2: locate and read the table ----------------
	loc_t          loc_b;
	loc_t          loc_e;
	logic [BW-1:0] ha_b;
	logic [BW-1:0] ha_e;
	logic [BW-1:0] ea_b;
	logic [BW-1:0] ea_e;

	assign loc_b = locate(p_b_s1, size_eff);
	assign loc_e = locate(p_e_s1, size_eff);
	assign ha_b  = BW'(loc_b.hd >> 1);
	assign ha_e  = BW'(loc_e.hd >> 1);
	assign ea_b  = loc_b.hd[0] ? ha_b + BW'(1) : ha_b;
	assign ea_e  = loc_e.hd[0] ? ha_e + BW'(1) : ha_e;

	logic        v_s2;
	logic [15:0] f_b_s2;
	logic [15:0] f_e_s2;
	logic        od_b_s2;
	logic        od_e_s2;
	logic [63:0] ev_b_s2;
	logic [63:0] ev_e_s2;
	logic [63:0] odd_b_s2;
	logic [63:0] odd_e_s2;
	logic [15:0] len_s2;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_odd) begin
			even_mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			ev_b_s2 <= even_mem[ea_b];
			ev_e_s2 <= even_mem[ea_e];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_odd) begin
			odd_mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			odd_b_s2 <= odd_mem[ha_b];
			odd_e_s2 <= odd_mem[ha_e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_b_s2  <= loc_b.f;
			f_e_s2  <= loc_e.f;
			od_b_s2 <= loc_b.hd[0];
			od_e_s2 <= loc_e.hd[0];
			len_s2  <= len_s1;
		end
	end

	// ---------------- s3: interpolate both samples ----------------
	logic [63:0] h_b;
	logic [63:0] t_b;
	logic [63:0] h_e;
	logic [63:0] t_e;

	assign h_b = od_b_s2 ? odd_b_s2 : ev_b_s2;
	assign t_b = od_b_s2 ? ev_b_s2  : odd_b_s2;
	assign h_e = od_e_s2 ? odd_e_s2 : ev_e_s2;
	assign t_e = od_e_s2 ? ev_e_s2  : odd_e_s2;

	logic        v_s3;
	logic [63:0] c_b_s3;
	logic [63:0] c_e_s3;
	logic [15:0] len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_interp
		always_ff @(posedge clk) begin
			if (adv) begin
				c_b_s3[16*c +: 16] <= interp(h_b[16*c +: 16], t_b[16*c +: 16], f_b_s2);
				c_e_s3[16*c +: 16] <= interp(h_e[16*c +: 16], t_e[16*c +: 16], f_e_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s3 <= len_s2;
		end
	end

	// ---------------- s4: average, transmittance ----------------
	logic [63:0] avg;

	always_comb begin
		logic [16:0] tmp;
		for (int c = 0; c < 4; c++) begin
			tmp = 17'(c_b_s3[16*c +: 16]) + 17'(c_e_s3[16*c +: 16]) + 17'd1;
			avg[16*c +: 16] = tmp[16:1];
		end
	end

	logic        v_s4;
	logic [47:0] rgb_s4;
	logic [16:0] t_s4;
	logic [15:0] len_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s4 <= avg[47:0];
			t_s4   <= 17'd65536 - 17'(avg[63:48]);
			len_s4 <= len_s3;
		end
	end

	// ---------------- s5: normalize to Q1.30 ----------------
	logic [4:0] lead;

	always_comb begin
		lead = '0;
		for (int b = 0; b < 17; b++) begin
			if (t_s4[b]) begin
				lead = 5'(b);
			end
		end
	end

	logic        v_s5;
	logic [47:0] rgb_s5;
	logic [4:0]  m_s5;
	logic [30:0] mant_s5;
	logic [15:0] len_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s5  <= rgb_s4;
			m_s5    <= lead;
			mant_s5 <= 31'(t_s4) << (5'd30 - lead);
			len_s5  <= len_s4;
		end
	end

	// ---------------- s6..s21: log2 fraction, one bit a stage ----------------
	log_t             lg_s [LOG_N];
	logic [LOG_N-1:0] lg_v_s;

	for (genvar i = 0; i < LOG_N; i++) begin : g_log
		log_t        src;
		logic        src_v;
		logic [61:0] sq;
		logic [31:0] sh;

		if (i == 0) begin : g_src
			assign src   = '{rgb: rgb_s5, m: m_s5, mant: mant_s5, frac: 16'h0000,
				len: len_s5};
			assign src_v = v_s5;
		end else begin : g_src
			assign src   = lg_s[i-1];
			assign src_v = lg_v_s[i-1];
		end

		assign sq = src.mant * src.mant;
		assign sh = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_v_s[i] <= 1'b0;
			end else if (adv) begin
				lg_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lg_s[i].rgb  <= src.rgb;
				lg_s[i].m    <= src.m;
				lg_s[i].mant <= sh[31] ? sh[31:1] : sh[30:0];
				lg_s[i].frac <= {src.frac[14:0], sh[31]};
				lg_s[i].len  <= src.len;
			end
		end
	end

	// ---------------- s22: scale -log2 by segment length ----------------
	logic [20:0] nlog;

	assign nlog = {5'd16 - lg_s[LOG_N-1].m, 16'h0000} - {5'b00000, lg_s[LOG_N-1].frac};

	logic             v_s22;
	logic [47:0]      rgb_s22;
	logic [NUM_W-1:0] num_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else if (adv) begin
			v_s22 <= lg_v_s[LOG_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s22 <= lg_s[LOG_N-1].rgb;
			num_s22 <= NUM_W'(nlog) * NUM_W'(lg_s[LOG_N-1].len);
		end
	end

	// ---------------- s23..s43: divide by step base, one bit a stage ----------------
	// Quotients of 2^21 and up flush the power to zero; flag them up front.
	quo_t             dv_s [DIV_N];
	logic [DIV_N-1:0] dv_v_s;

	for (genvar i = 0; i < DIV_N; i++) begin : g_div
		localparam int J = DIV_N - 1 - i;
		quo_t             src;
		logic             src_v;
		logic [NUM_W-1:0] dvs;
		logic             ge;

		if (i == 0) begin : g_src
			assign src   = '{rgb: rgb_s22, rem: num_s22, quo: '0,
				ovf: (num_s22[NUM_W-1:DIV_N] >= base_eff)};
			assign src_v = v_s22;
		end else begin : g_src
			assign src   = dv_s[i-1];
			assign src_v = dv_v_s[i-1];
		end

		assign dvs = NUM_W'(base_eff) << J;
		assign ge  = (src.rem >= dvs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else if (adv) begin
				dv_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i].rgb    <= src.rgb;
				dv_s[i].rem    <= ge ? src.rem - dvs : src.rem;
				dv_s[i].quo    <= src.quo | (DIV_N'(ge) << J);
				dv_s[i].ovf    <= src.ovf;
			end
		end
	end

	// ---------------- s44..s59: 2^-frac as a product of roots ----------------
	exp_t             ex_s [EXP_N];
	logic [EXP_N-1:0] ex_v_s;

	for (genvar i = 0; i < EXP_N; i++) begin : g_exp
		localparam logic [30:0] RK = root_at(i + 1);
		exp_t        src;
		logic        src_v;
		logic [61:0] pm;
		logic [61:0] pr;

		if (i == 0) begin : g_src
			assign src   = '{rgb: dv_s[DIV_N-1].rgb, prod: 31'd1 << 30,
				quo: dv_s[DIV_N-1].quo, ovf: dv_s[DIV_N-1].ovf};
			assign src_v = dv_v_s[DIV_N-1];
		end else begin : g_src
			assign src   = ex_s[i-1];
			assign src_v = ex_v_s[i-1];
		end

		assign pm = src.prod * RK;
		assign pr = pm + (62'd1 << 29);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_v_s[i] <= 1'b0;
			end else if (adv) begin
				ex_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ex_s[i].rgb  <= src.rgb;
				ex_s[i].prod <= src.quo[EXP_N-1-i] ? pr[60:30] : src.prod;
				ex_s[i].quo  <= src.quo;
				ex_s[i].ovf  <= src.ovf;
			end
		end
	end

	// ---------------- s60: integer shift, corrected alpha ----------------
	logic [4:0]  zi;
	logic        flush;
	logic [31:0] rsum;
	logic [31:0] pwr;
	logic [16:0] one_minus;
	logic [15:0] a_new;

	assign zi        = ex_s[EXP_N-1].quo[DIV_N-1:16];
	assign flush     = ex_s[EXP_N-1].ovf || (zi > 5'd16);
	assign rsum      = 32'(ex_s[EXP_N-1].prod) + (32'd1 << (6'(zi) + 6'd13));
	assign pwr       = flush ? 32'd0 : rsum >> (6'(zi) + 6'd14);
	assign one_minus = 17'd65536 - pwr[16:0];
	assign a_new     = (pwr == '0) ? 16'hFFFF : one_minus[15:0];

	logic        v_s60;
	logic [47:0] rgb_s60;
	logic [15:0] alpha_s60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s60 <= 1'b0;
		end else if (adv) begin
			v_s60 <= ex_v_s[EXP_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s60   <= ex_s[EXP_N-1].rgb;
			alpha_s60 <= a_new;
		end
	end

	// ---------------- premultiply into output register / skid ----------------
	out_res_t    res;
	logic [31:0] pre_r;
	logic [31:0] pre_g;
	logic [31:0] pre_b;

	assign pre_r = 32'(rgb_s60[15:0])  * 32'(alpha_s60) + 32'd32768;
	assign pre_g = 32'(rgb_s60[31:16]) * 32'(alpha_s60) + 32'd32768;
	assign pre_b = 32'(rgb_s60[47:32]) * 32'(alpha_s60) + 32'd32768;

	assign res.out_red   = pre_r[31:16];
	assign res.out_green = pre_g[31:16];
	assign res.out_blue  = pre_b[31:16];
	assign res.out_alpha = alpha_s60;

	// Drain the skid first when the output frees; park a new result in the
	// skid when the output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			if (skid_v_q) begin
				out_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				out_valid <= v_s60;
			end
		end else if (v_s60 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || !out_stall) begin
			out_req <= skid_v_q ? skid_q : res;
		end else if (v_s60 && !skid_v_q) begin
			skid_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tfsc_checker.sv -----
// ----------------------------------------------------------------------------
// tfsc_checker
// Port-level checks of the classifier's stall and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire tfsc_pkg::out_res_t out_req
);

	// input backs up only behind a held result
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// the skid cannot fill while the output was empty
	a_no_stall_after_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(out_valid) |-> !in_stall)
		else $error("in_stall after an empty output");

	// a taken result empties the skid by the next cycle
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("in_stall held after output was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_req))
		else $error("stalled result changed");

endmodule

bind transfer_function_segment_classify tfsc_checker u_tfsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_req   (out_req)
);

`default_nettype wire
